[hdl/tqws_pkg.sv]
// package: shared types and codes for the two-queue weighted scheduler
`default_nettype none

package tqws_pkg;

  // field widths
  localparam int TAG_W     = 16;
  localparam int MODE_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int WEIGHT_W  = 4;
  localparam int CFG_IDX_W = 1;

  typedef logic [TAG_W-1:0]     tag_t;
  typedef logic [MODE_W-1:0]    mode_t;
  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [WEIGHT_W-1:0]  weight_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // input modes (any other code serves)
  localparam mode_t MODE_ENQ_URGENT   = 2'd0;
  localparam mode_t MODE_ENQ_STANDARD = 2'd1;
  localparam mode_t MODE_SERVE        = 2'd2;

  // result status codes
  localparam status_t ST_ENQUEUED = 2'd0;
  localparam status_t ST_FULL     = 2'd1;
  localparam status_t ST_SERVED   = 2'd2;
  localparam status_t ST_NONE     = 2'd3;

  // configuration register indexes
  localparam cfg_idx_t CFG_URGENT_WEIGHT   = 1'd0;
  localparam cfg_idx_t CFG_STANDARD_WEIGHT = 1'd1;

  // weight reset values
  localparam weight_t URGENT_WEIGHT_RST   = 4'd3;
  localparam weight_t STANDARD_WEIGHT_RST = 4'd5;

endpackage

`default_nettype wire

[hdl/tqws_ifs.sv]
// interfaces: request and result channels of the scheduler
`default_nettype none

interface tqws_req_if;
  logic                 valid;
  logic                 ready;
  tqws_pkg::mode_t      mode;
  tqws_pkg::tag_t       order_tag;

  modport source (output valid, output mode, output order_tag, input ready);
  modport sink   (input valid, input mode, input order_tag, output ready);
endinterface

interface tqws_rsp_if;
  logic                 valid;
  logic                 ready;
  tqws_pkg::status_t    status;
  tqws_pkg::tag_t       served_tag;
  logic                 from_standard;

  modport source (output valid, output status, output served_tag, output from_standard,
                  input ready);
  modport sink   (input valid, input status, input served_tag, input from_standard,
                  output ready);
endinterface

`default_nettype wire

[hdl/two_queue_weighted_scheduler_top.sv]
// top level: two-queue weighted round-robin tag scheduler
//
// Usage: each request beat on in_bus either enqueues order_tag into the urgent
// or standard ring, or asks for the next tag to serve. Every request gives
// exactly one result beat on out_bus: enqueued, rejected (queue full), served
// (with the tag and its queue) or nothing to serve.
// Serving runs in groups: up to urgent_weight urgent tags (one when it is zero), then up to
// standard_weight standard tags (likewise); a group ends early when its queue is empty.
// Weights are written through cfg_we/cfg_index/cfg_wdata while idle.
// An enqueue or an empty serve shows its result in the cycle after acceptance;
// a popping serve passes through the pending-read register, then the output register.
// Enqueues go at one per cycle while results are taken; a popping serve holds off
// new requests until its tag returns from the registered read of the queue memory.
// The result sits in an output register; a new request is taken in the same
// cycle the old result is taken, so a stalled receiver stalls the input.
// Reset (synchronous, rst_n low): both rings empty, urgent group first,
// weights 3 and 5. Queue memories are not cleared; only written slots are read.
`default_nettype none

module two_queue_weighted_scheduler_top #(
  parameter int QUEUE_DEPTH = 128
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  tqws_req_if.sink                  in_bus,
  tqws_rsp_if.source                out_bus,
  input  wire logic                 cfg_we,
  input  wire tqws_pkg::cfg_idx_t   cfg_index,
  input  wire tqws_pkg::weight_t    cfg_wdata
);

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);

  // control state
  logic [PTR_W-1:0]  u_head_r, u_head_nxt, u_tail_r, u_tail_nxt;
  logic [PTR_W-1:0]  s_head_r, s_head_nxt, s_tail_r, s_tail_nxt;
  logic [FILL_W-1:0] u_fill_r, u_fill_nxt, s_fill_r, s_fill_nxt;
  logic              grp_std_r, grp_std_nxt;
  tqws_pkg::weight_t served_r, served_nxt;
  tqws_pkg::weight_t u_weight_r, s_weight_r;
  logic              rd_pend_r, rd_pend_nxt;
  logic              rd_std_r, rd_std_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  tqws_pkg::status_t out_status_r, out_status_nxt;
  tqws_pkg::tag_t    out_tag_r, out_tag_nxt;
  logic              out_std_r, out_std_nxt;

  // memory ports
  logic              u_we, s_we;
  tqws_pkg::tag_t    u_rdata, s_rdata;

  logic              in_fire;
  logic              pick_std;
  tqws_pkg::weight_t cnt, cnt_inc, weight;

  assign in_bus.ready = !rd_pend_r && (!out_valid_r || out_bus.ready);
  assign in_fire      = in_bus.valid && in_bus.ready;

  assign out_bus.valid         = out_valid_r;
  assign out_bus.status        = out_status_r;
  assign out_bus.served_tag    = out_tag_r;
  assign out_bus.from_standard = out_std_r;

  // queue memories, read address always at the head
  tqws_ram #(.WIDTH(tqws_pkg::TAG_W), .DEPTH(QUEUE_DEPTH)) u_urgent_ram (
    .clk   (clk),
    .we    (u_we),
    .waddr (u_tail_r),
    .wdata (in_bus.order_tag),
    .raddr (u_head_r),
    .rdata (u_rdata)
  );

  tqws_ram #(.WIDTH(tqws_pkg::TAG_W), .DEPTH(QUEUE_DEPTH)) u_standard_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_tail_r),
    .wdata (in_bus.order_tag),
    .raddr (s_head_r),
    .rdata (s_rdata)
  );

  // group selection for a serve: switch when the current group's queue is empty
  always_comb begin
    pick_std = grp_std_r;
    cnt      = served_r;
    if (grp_std_r ? (s_fill_r == '0) : (u_fill_r == '0)) begin
      pick_std = !grp_std_r;
      cnt      = '0;
    end
    cnt_inc = cnt + tqws_pkg::weight_t'(1);
    weight  = pick_std ? s_weight_r : u_weight_r;
  end

  // request handling and output register loading
  always_comb begin
    u_head_nxt     = u_head_r;
    u_tail_nxt     = u_tail_r;
    u_fill_nxt     = u_fill_r;
    s_head_nxt     = s_head_r;
    s_tail_nxt     = s_tail_r;
    s_fill_nxt     = s_fill_r;
    grp_std_nxt    = grp_std_r;
    served_nxt     = served_r;
    rd_pend_nxt    = 1'b0;
    rd_std_nxt     = rd_std_r;
    u_we           = 1'b0;
    s_we           = 1'b0;
    out_valid_nxt  = out_valid_r && !out_bus.ready;
    out_status_nxt = out_status_r;
    out_tag_nxt    = out_tag_r;
    out_std_nxt    = out_std_r;

    if (rd_pend_r) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = tqws_pkg::ST_SERVED;
      out_tag_nxt    = rd_std_r ? s_rdata : u_rdata;
      out_std_nxt    = rd_std_r;
    end else if (in_fire) begin
      out_valid_nxt = 1'b1;
      out_tag_nxt   = '0;
      out_std_nxt   = 1'b0;
      unique case (in_bus.mode)
        tqws_pkg::MODE_ENQ_URGENT: begin
          if (u_fill_r == FILL_MAX) begin
            out_status_nxt = tqws_pkg::ST_FULL;
          end else begin
            out_status_nxt = tqws_pkg::ST_ENQUEUED;
            u_we           = 1'b1;
            u_tail_nxt     = (u_tail_r == PTR_LAST) ? '0 : u_tail_r + PTR_W'(1);
            u_fill_nxt     = u_fill_r + FILL_W'(1);
          end
        end
        tqws_pkg::MODE_ENQ_STANDARD: begin
          if (s_fill_r == FILL_MAX) begin
            out_status_nxt = tqws_pkg::ST_FULL;
          end else begin
            out_status_nxt = tqws_pkg::ST_ENQUEUED;
            s_we           = 1'b1;
            s_tail_nxt     = (s_tail_r == PTR_LAST) ? '0 : s_tail_r + PTR_W'(1);
            s_fill_nxt     = s_fill_r + FILL_W'(1);
          end
        end
        default: begin
          if (u_fill_r == '0 && s_fill_r == '0) begin
            out_status_nxt = tqws_pkg::ST_NONE;
          end else begin
            // pop now, result follows when the read data returns
            out_valid_nxt = 1'b0;
            rd_pend_nxt   = 1'b1;
            rd_std_nxt    = pick_std;
            if (pick_std) begin
              s_head_nxt = (s_head_r == PTR_LAST) ? '0 : s_head_r + PTR_W'(1);
              s_fill_nxt = s_fill_r - FILL_W'(1);
            end else begin
              u_head_nxt = (u_head_r == PTR_LAST) ? '0 : u_head_r + PTR_W'(1);
              u_fill_nxt = u_fill_r - FILL_W'(1);
            end
            if (cnt_inc >= weight) begin
              grp_std_nxt = !pick_std;
              served_nxt  = '0;
            end else begin
              grp_std_nxt = pick_std;
              served_nxt  = cnt_inc;
            end
          end
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_head_r    <= '0;
      u_tail_r    <= '0;
      u_fill_r    <= '0;
      s_head_r    <= '0;
      s_tail_r    <= '0;
      s_fill_r    <= '0;
      grp_std_r   <= 1'b0;
      served_r    <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      u_head_r    <= u_head_nxt;
      u_tail_r    <= u_tail_nxt;
      u_fill_r    <= u_fill_nxt;
      s_head_r    <= s_head_nxt;
      s_tail_r    <= s_tail_nxt;
      s_fill_r    <= s_fill_nxt;
      grp_std_r   <= grp_std_nxt;
      served_r    <= served_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // weight registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_weight_r <= tqws_pkg::URGENT_WEIGHT_RST;
      s_weight_r <= tqws_pkg::STANDARD_WEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tqws_pkg::CFG_URGENT_WEIGHT:   u_weight_r <= cfg_wdata;
        tqws_pkg::CFG_STANDARD_WEIGHT: s_weight_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_std_r     <= rd_std_nxt;
    out_status_r <= out_status_nxt;
    out_tag_r    <= out_tag_nxt;
    out_std_r    <= out_std_nxt;
  end

  // no request is taken while a queue read is outstanding
  a_no_accept_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> !in_fire)
    else $error("request accepted during pending queue read");

  // a popping serve always leads to a pending read, which then loads the result
  a_serve_reads: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_bus.mode != tqws_pkg::MODE_ENQ_URGENT
      && in_bus.mode != tqws_pkg::MODE_ENQ_STANDARD
      && (u_fill_r != '0 || s_fill_r != '0) |=> rd_pend_r ##1 out_valid_r)
    else $error("serve did not produce a result after the read");

  // fill counts never pass the ring depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    u_fill_r <= FILL_MAX && s_fill_r <= FILL_MAX)
    else $error("queue fill count out of range");

  // served group count stays below the active weight when the weight is nonzero
  a_group_count: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rd_pend_nxt) && rst_n && $past(rst_n) |->
      served_r == '0 || served_r < (grp_std_r ? s_weight_r : u_weight_r))
    else $error("group count reached its weight without switching");

endmodule

`default_nettype wire

[hdl/tqws_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none

module tqws_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
